// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/bbt_pkg.sv
// ----------------------------------------------------------------------------
// bbt_pkg
// Widths, codes and control structs of the branch bias table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbt_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam int ADDR_W   = 64;
    localparam int THREAD_W = 3;
    localparam int COUNT_W  = 30;
    localparam int ENTRY_W  = 32;
    localparam int SHIFT_W  = 2;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 2'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    // entry layout: direction, pending fault, run count above
    localparam int ENTRY_DIR_BIT   = 0;
    localparam int ENTRY_FAULT_BIT = 1;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic read;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/bbt_in_if.sv
// ----------------------------------------------------------------------------
// bbt_in_if
// Request channel: lookup or update of one branch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bbt_in_if;
    import bbt_pkg::*;

    logic                valid;
    logic                ready;
    logic                command;
    logic [ADDR_W-1:0]   branch_address;
    logic [THREAD_W-1:0] thread_id;
    logic                outcome_taken;

    modport source (
        output valid,
        output command,
        output branch_address,
        output thread_id,
        output outcome_taken,
        input  ready
    );

    modport sink (
        input  valid,
        input  command,
        input  branch_address,
        input  thread_id,
        input  outcome_taken,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/core/bbt_out_if.sv
// ----------------------------------------------------------------------------
// bbt_out_if
// Response channel: hit, bias direction and run count of one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bbt_out_if;
    import bbt_pkg::*;

    logic               valid;
    logic               ready;
    logic               hit;
    logic               bias_taken;
    logic [COUNT_W-1:0] run_count;

    modport source (
        output valid,
        output hit,
        output bias_taken,
        output run_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  hit,
        input  bias_taken,
        input  run_count,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/core/bbt_ctrl.sv
// ----------------------------------------------------------------------------
// bbt_ctrl
// Sequencer: clearing pass after reset, then capture, read and commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbt_ctrl
    import bbt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EXEC  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // hold the item until the result register can take it
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/bbt_datapath.sv
// ----------------------------------------------------------------------------
// bbt_datapath
// Item registers, tag and entry memories, entry update and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbt_datapath
    import bbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [SHIFT_W-1:0]  cfg_wdata,
    input  wire ctrl_cmd_t           cmd,
    output dp_status_t               status,
    input  wire logic                in_command,
    input  wire logic [ADDR_W-1:0]   in_address,
    input  wire logic [THREAD_W-1:0] in_thread,
    input  wire logic                in_taken,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic                     out_hit,
    output logic                     out_bias,
    output logic [COUNT_W-1:0]       out_count
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int TAG_W = ADDR_W - IDX_W + THREAD_W;

    logic [SHIFT_W-1:0]  shift_reg;
    logic                cmd_reg;
    logic [ADDR_W-1:0]   key_reg;
    logic [THREAD_W-1:0] thr_reg;
    logic                taken_reg;
    logic [IDX_W-1:0]    clr_idx_reg;
    logic [IDX_W-1:0]    clr_idx_next;

    // valid mark sits above the entry bits
    logic [ENTRY_W:0]    ent_mem [TABLE_ENTRIES];
    logic [TAG_W-1:0]    tag_mem [TABLE_ENTRIES];
    logic [ENTRY_W:0]    ent_rd_reg;
    logic [TAG_W-1:0]    tag_rd_reg;

    logic                out_valid_reg;
    logic                out_hit_reg;
    logic                out_bias_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic [IDX_W-1:0]    line_idx;
    logic [TAG_W-1:0]    tag_key;
    logic                is_update;
    logic                hit;
    logic [ENTRY_W-1:0]  old_entry;
    logic [COUNT_W-1:0]  old_count;
    logic [ENTRY_W-1:0]  new_entry;
    logic                ent_we;
    logic [IDX_W-1:0]    ent_waddr;
    logic [ENTRY_W:0]    ent_wdata;
    logic                tag_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            shift_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg   <= in_command;
            key_reg   <= in_address >> shift_reg;
            thr_reg   <= in_thread;
            taken_reg <= in_taken;
        end
    end

    assign clr_idx_next = clr_idx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_idx_reg <= clr_idx_next;
        end
    end

    assign status.clear_last = &clr_idx_reg;

    assign line_idx  = key_reg[IDX_W-1:0];
    assign tag_key   = {key_reg[ADDR_W-1:IDX_W], thr_reg};
    assign is_update = (cmd_reg == CMD_UPDATE);

    assign hit       = ent_rd_reg[ENTRY_W] && (tag_rd_reg == tag_key);
    assign old_entry = ent_rd_reg[ENTRY_W-1:0];
    assign old_count = old_entry[ENTRY_W-1:ENTRY_W-COUNT_W];

    always_comb
    begin
        new_entry = old_entry;
        if (taken_reg == old_entry[ENTRY_DIR_BIT])
        begin
            if (old_count != COUNT_MAX)
            begin
                new_entry[ENTRY_W-1:ENTRY_W-COUNT_W] = old_count + 1'b1;
            end
        end
        else if (!old_entry[ENTRY_FAULT_BIT])
        begin
            new_entry[ENTRY_FAULT_BIT] = 1'b1;
        end
        else
        begin
            // a contrary outcome with the fault bit already set flips the bias
            new_entry                  = '0;
            new_entry[ENTRY_W-COUNT_W] = 1'b1;
            new_entry[ENTRY_DIR_BIT]   = taken_reg;
        end
    end

    // a retag keeps the counter bits, so the tag is simply rewritten on update
    assign tag_we    = cmd.commit && is_update;
    assign ent_we    = cmd.clear_wr || tag_we;
    assign ent_waddr = cmd.clear_wr ? clr_idx_reg : line_idx;
    assign ent_wdata = cmd.clear_wr ? '0 : {1'b1, new_entry};

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (cmd.read)
        begin
            ent_rd_reg <= ent_mem[line_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[line_idx] <= tag_key;
        end
        if (cmd.read)
        begin
            tag_rd_reg <= tag_mem[line_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg   <= hit;
            out_bias_reg  <= (!is_update && hit) ? old_entry[ENTRY_DIR_BIT] : 1'b0;
            out_count_reg <= (!is_update && hit) ? old_count : '0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign out_bias  = out_bias_reg;
    assign out_count = out_count_reg;

endmodule

`default_nettype wire

// File: rtl/core/branch_bias_table_core.sv
// ----------------------------------------------------------------------------
// branch_bias_table_core
// Direct-mapped branch bias table with lookup and update commands.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all TABLE_ENTRIES entries
// (1024 by default) with request.ready low; configuration writes are taken
// meanwhile. Each item then passes from acceptance to result through capture
// and address shift, registered read of the tag and entry memories, then hit
// check, entry update and write-back into the result register. The single
// read port of the table and its registered read data keep one item in
// flight, so no item is accepted until the last one is committed; the result
// register lets the next item be accepted while a result waits.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module branch_bias_table_core
    import bbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    bbt_in_if.sink                  request,
    bbt_out_if.source               response,
    input  wire logic               cfg_we,
    input  wire logic [SHIFT_W-1:0] cfg_wdata
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_ready;

    bbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bbt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .status     (status),
        .in_command (request.command),
        .in_address (request.branch_address),
        .in_thread  (request.thread_id),
        .in_taken   (request.outcome_taken),
        .out_ready  (response.ready),
        .out_valid  (response.valid),
        .out_hit    (response.hit),
        .out_bias   (response.bias_taken),
        .out_count  (response.run_count)
    );

    assign request.ready = in_ready;

    // one item in flight at a time
    `ASSERT_NEXT(a_single_item, clk, rst_n, request.valid && request.ready, !request.ready, "item accepted while another is in flight")
    `ASSERT_IMPLY(a_commit_free, clk, rst_n, cmd.commit, status.out_free, "result overwrites a waiting result")
    `ASSERT_NEXT(a_commit_out, clk, rst_n, cmd.commit, response.valid, "committed item gives no result")
    `ASSERT_IMPLY(a_clear_quiet, clk, rst_n, cmd.clear_wr, !request.ready && !cmd.commit, "item taken during clearing pass")

endmodule

`default_nettype wire
